// File: rtl/rmm_pkg.sv
// rmm_pkg: shared types and constants for the running median multiset block
// no dependencies

package rmm_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 7;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef logic signed [DataW-1:0] data_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic upd_ok;
    op_e  op;
  } cell_ctrl_t;

endpackage

// File: rtl/rmm_in_if.sv
// rmm_in_if: input channel, valid/ready with operation and value
// depends on rmm_pkg

interface rmm_in_if;
  logic            valid;
  logic            ready;
  logic            operation;
  rmm_pkg::data_t  value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// File: rtl/rmm_out_if.sv
// rmm_out_if: result channel, valid/ready with median, flags and count
// depends on rmm_pkg

interface rmm_out_if;
  logic                          valid;
  logic                          ready;
  rmm_pkg::data_t                median;
  logic                          is_empty;
  logic [rmm_pkg::CountW-1:0]    held_count;
  logic                          not_found;
  logic                          dropped_full;

  modport source (output valid, output median, output is_empty, output held_count,
                  output not_found, output dropped_full, input ready);
  modport sink   (input valid, input median, input is_empty, input held_count,
                  input not_found, input dropped_full, output ready);
endinterface

// File: rtl/rmm_cell.sv
// rmm_cell: one slot of the sorted chain, holds a value and its compare flags
// depends on rmm_pkg

module rmm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmm_pkg::cell_ctrl_t ctrl_i,
  input  rmm_pkg::data_t      value_i,
  input  logic                valid_i,
  input  rmm_pkg::data_t      left_val_i,
  input  logic                left_gt_i,
  input  rmm_pkg::data_t      right_val_i,
  output rmm_pkg::data_t      val_o,
  output logic                gt_o,
  output logic                hit_o
);

  rmm_pkg::data_t val_q, val_d;
  logic           gt_q, gt_d;
  logic           eq_q, eq_d;

  // add: slot moves when it holds a larger value or is empty
  // remove: slot moves when it holds a value at or above the key
  always_comb begin
    if (ctrl_i.op == rmm_pkg::OP_ADD) begin
      gt_d = !valid_i || (val_q > value_i);
    end else begin
      gt_d = valid_i && (val_q >= value_i);
    end
    eq_d = valid_i && (val_q == value_i);
  end

  always_comb begin
    val_d = val_q;
    if (ctrl_i.upd_en && ctrl_i.upd_ok && gt_q) begin
      if (ctrl_i.op == rmm_pkg::OP_ADD) begin
        val_d = left_gt_i ? left_val_i : value_i;
      end else begin
        val_d = right_val_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      gt_q <= gt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign gt_o  = gt_q;
  // first slot at or above the key holds it exactly
  assign hit_o = gt_q && !left_gt_i && eq_q;

endmodule

// File: rtl/running_median_multiset.sv
// running_median_multiset: top level, sorted chain of cells with a small sequencer
// depends on rmm_pkg, rmm_in_if, rmm_out_if, rmm_cell
//
// channel | modport      | payload                                          | direction
// in_i    | rmm_in_if    | operation, value                                 | in
// out_o   | rmm_out_if   | median, is_empty, held_count, not_found, dropped | out
//
// each item passes four steps: accept, compare in every cell, shift the chain,
// select the median into the output register
// the selection step waits while an earlier result still sits unread in the output
// register; the input is taken again as soon as the sequencer is back in idle
// reset clears the count, the sequencer and the output valid; stored values need none

module running_median_multiset #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmm_in_if.sink    in_i,
  rmm_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  rmm_pkg::op_e        op_q;
  rmm_pkg::data_t      key_q;
  logic                nf_q, nf_d;
  logic                drop_q, drop_d;

  // output register
  logic                out_valid_q, out_valid_d;
  rmm_pkg::data_t      med_q;
  logic                empty_q;
  logic [rmm_pkg::CountW-1:0] held_q;
  logic                out_nf_q, out_drop_q;

  rmm_pkg::cell_ctrl_t ctrl;
  rmm_pkg::data_t      cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;
  logic [CAPACITY-1:0] cell_hit;
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_sel;

  logic                in_xfer;
  logic                out_free;
  logic                found;
  logic                full;
  logic                upd_ok;
  logic [CntW-1:0]     rank;
  rmm_pkg::data_t      med_sel;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign found    = |cell_hit;
  assign full     = (count_q == CntW'(CAPACITY));
  assign upd_ok   = (op_q == rmm_pkg::OP_ADD) ? !full : found;

  assign in_i.ready = (state_q == S_IDLE);

  // broadcast control to the chain
  always_comb begin
    ctrl.cmp_en = (state_q == S_CMP);
    ctrl.upd_en = (state_q == S_UPD);
    ctrl.upd_ok = upd_ok;
    ctrl.op     = op_q;
  end

  // the chain: inner cells see both neighbors; the first cell's left is the key
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rmm_pkg::data_t left_val;
    rmm_pkg::data_t right_val;
    logic           left_gt;

    assign cell_valid[i] = (CntW'(i) < count_q);
    assign cell_sel[i]   = (CntW'(i) == rank);

    if (i == 0) begin : g_first
      assign left_val = key_q;
      assign left_gt  = 1'b0;
    end else begin : g_inner
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_body
      assign right_val = cell_val[i+1];
    end

    rmm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .value_i     (key_q),
      .valid_i     (cell_valid[i]),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .right_val_i (right_val),
      .val_o       (cell_val[i]),
      .gt_o        (cell_gt[i]),
      .hit_o       (cell_hit[i])
    );
  end

  // lower median sits at rank (count-1)/2
  assign rank = (count_q - CntW'(1)) >> 1;

  // one-hot and-or pick of the median slot
  always_comb begin
    med_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      med_sel = med_sel | (cell_val[i] & {rmm_pkg::DataW{cell_sel[i]}});
    end
  end

  // sequencer and count
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    nf_d        = nf_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        nf_d   = (op_q == rmm_pkg::OP_REMOVE) && !found;
        drop_d = (op_q == rmm_pkg::OP_ADD) && full;
        if (upd_ok) begin
          if (op_q == rmm_pkg::OP_ADD) begin
            count_d = count_q + CntW'(1);
          end else begin
            count_d = count_q - CntW'(1);
          end
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        // hold here until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      nf_q        <= 1'b0;
      drop_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      nf_q        <= nf_d;
      drop_q      <= drop_d;
    end
  end

  // item capture and result payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= rmm_pkg::op_e'(in_i.operation);
      key_q <= in_i.value;
    end
    if ((state_q == S_OUT) && out_free) begin
      med_q      <= (count_q == '0) ? '0 : med_sel;
      empty_q    <= (count_q == '0);
      held_q     <= rmm_pkg::CountW'(count_q);
      out_nf_q   <= nf_q;
      out_drop_q <= drop_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.median       = med_q;
  assign out_o.is_empty     = empty_q;
  assign out_o.held_count   = held_q;
  assign out_o.not_found    = out_nf_q;
  assign out_o.dropped_full = out_drop_q;

endmodule
